// ----- src/lapet_pkg.sv -----
// Shared types and constants for the cross Laplacian edge threshold block.
package lapet_pkg;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int WGT_W   = 6;
	localparam int THR_W   = 9;
	localparam int NSUM_W  = 10;
	localparam int CPROD_W = WGT_W + PIX_W + 1;
	localparam int NPROD_W = WGT_W + NSUM_W + 1;
	localparam int SUM_W   = NPROD_W + 1;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_W  = 3'd2;
	localparam logic [IDX_W-1:0] REG_NEIGHB_W  = 3'd3;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd4;

	localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd480;
	localparam logic [WGT_W-1:0] CENTER_W_RST  = 6'd4;
	localparam logic [WGT_W-1:0] NEIGHB_W_RST  = 6'h3F;
	localparam logic [THR_W-1:0] THRESHOLD_RST = 9'd26;

	typedef struct packed {
		logic             command;
		logic [PIX_W-1:0] grey_pixel;
	} sample_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic             last_of_frame;
	} result_t;

	typedef struct packed {
		logic signed [WGT_W-1:0] center;
		logic signed [WGT_W-1:0] neighbour;
	} weights_t;

	// Kernel products of one item, queued between front and back.
	typedef struct packed {
		logic signed [CPROD_W-1:0] cprod;
		logic signed [NPROD_W-1:0] nprod;
		logic                      last;
	} prod_t;

endpackage

// ----- src/lapet_front.sv -----
// Front end: raster counters, two-row line memory, window and kernel products.
module lapet_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  lapet_pkg::sample_t                sample,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
	input  lapet_pkg::weights_t               weights,
	input  logic                              restart,
	output logic                              push,
	output lapet_pkg::prod_t                  prod,
	output logic [1:0]                        inflight
);
	import lapet_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int EW_W  = $clog2(MAX_WIDTH + 1);
	localparam int EH_W  = $clog2(MAX_HEIGHT + 1);

	// Each column holds {row above, two rows above} relative to the incoming row.
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [PIX_W-1:0]   prev_mid_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;

	logic             is_pixel, take_pix, take_flush, active, emit;
	logic             last_col, last_row, row_zero;
	logic [COL_W-1:0] rd_addr;
	logic [PIX_W-1:0] up_now, uu_now;

	logic             v_s1;
	logic [PIX_W-1:0] left_s1, mid_s1, uu_s1, down_s1;
	logic             has_left_s1, has_right_s1, has_up_s1, has_down_s1, last_s1;

	logic              v_s2;
	logic [NSUM_W-1:0] nsum_c, nsum_s2;
	logic [PIX_W-1:0]  center_s2;
	logic              last_s2;

	logic                      v_s3;
	prod_t                     prod_s3;
	logic signed [CPROD_W-1:0] cprod_c;
	logic signed [NPROD_W-1:0] nprod_c;

	assign is_pixel   = sample.command == CMD_PIXEL;
	assign take_pix   = accept && is_pixel && !done_q;
	assign take_flush = accept && !is_pixel && done_q;
	assign active     = take_pix || take_flush;
	assign last_col   = (EW_W'(col_q) + EW_W'(1)) == width;
	assign last_row   = (EH_W'(row_q) + EH_W'(1)) == height;
	assign row_zero   = row_q == '0;
	assign emit       = take_flush || (take_pix && !row_zero);
	// Prefetch the next column; the last column prefetches column 0 for the next row.
	assign rd_addr    = last_col ? '0 : col_q + COL_W'(1);
	assign up_now     = rd_q[2*PIX_W-1:PIX_W];
	assign uu_now     = rd_q[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (take_pix) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					done_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (take_flush) begin
			if (last_col) begin
				col_q  <= '0;
				row_q  <= '0;
				done_q <= 1'b0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_pix) begin
			line_mem[col_q] <= {sample.grey_pixel, up_now};
		end
		if (active) begin
			rd_q       <= line_mem[rd_addr];
			prev_mid_q <= up_now;
		end
	end

	// s1: window captured; right neighbour arrives from the prefetch next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_s1      <= prev_mid_q;
			mid_s1       <= up_now;
			uu_s1        <= uu_now;
			down_s1      <= sample.grey_pixel;
			has_left_s1  <= col_q != '0;
			has_right_s1 <= !last_col;
			has_up_s1    <= take_flush || (row_q > ROW_W'(1));
			has_down_s1  <= take_pix;
			last_s1      <= take_flush && last_col;
		end
	end

	always_comb begin
		nsum_c = '0;
		if (has_left_s1)  nsum_c = nsum_c + NSUM_W'(left_s1);
		if (has_right_s1) nsum_c = nsum_c + NSUM_W'(up_now);
		if (has_up_s1)    nsum_c = nsum_c + NSUM_W'(uu_s1);
		if (has_down_s1)  nsum_c = nsum_c + NSUM_W'(down_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			nsum_s2   <= nsum_c;
			center_s2 <= mid_s1;
			last_s2   <= last_s1;
		end
	end

	assign cprod_c = weights.center * $signed({1'b0, center_s2});
	assign nprod_c = weights.neighbour * $signed({1'b0, nsum_s2});

	always_ff @(posedge clk) begin
		if (v_s2) begin
			prod_s3.cprod <= cprod_c;
			prod_s3.nprod <= nprod_c;
			prod_s3.last  <= last_s2;
		end
	end

	assign push     = v_s3;
	assign prod     = prod_s3;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

	a_rw_addr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		take_pix |-> rd_addr != col_q)
		else $error("line memory read and write collide");

	a_first_row_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take_pix && row_zero && !restart) |=> !v_s1)
		else $error("first-row pixel produced a result");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		EW_W'(col_q) < width)
		else $error("column counter beyond frame width");

endmodule

// ----- src/lapet_fifo.sv -----
// Small register queue of kernel products between front and back.
module lapet_fifo #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  lapet_pkg::prod_t           wr_data,
	input  logic                       rd_en,
	output lapet_pkg::prod_t           rd_data,
	output logic                       not_empty,
	output logic [$clog2(DEPTH):0]     count
);
	import lapet_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	prod_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data   = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (PTR_W+1)'(DEPTH)) |-> (!wr_en || rd_en))
		else $error("product queue overflow");

endmodule

// ----- src/lapet_back.sv -----
// Back end: sum, clamp, threshold and the result register.
module lapet_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	input  lapet_pkg::prod_t                        head,
	input  logic signed [lapet_pkg::THR_W-1:0]      threshold,
	input  logic                                    pop,
	output logic                                    q_pop,
	output lapet_pkg::result_t                      result,
	output logic                                    empty
);
	import lapet_pkg::*;

	logic                    out_v_q;
	result_t                 result_q;
	logic signed [SUM_W-1:0] sum_c;
	logic [PIX_W-1:0]        clamp_c;
	logic                    hit_c;

	assign sum_c = SUM_W'(head.cprod) + SUM_W'(head.nprod);

	always_comb begin
		if (sum_c[SUM_W-1]) begin
			clamp_c = '0;
		end else if (sum_c > $signed(SUM_W'(PIXEL_MAX))) begin
			clamp_c = PIXEL_MAX;
		end else begin
			clamp_c = sum_c[PIX_W-1:0];
		end
	end

	assign hit_c = $signed({2'b00, clamp_c}) > $signed({threshold[THR_W-1], threshold});
	assign q_pop = q_valid && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (q_pop) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			result_q.edge_value    <= hit_c ? PIXEL_MAX : '0;
			result_q.last_of_frame <= head.last;
		end
	end

	assign result = result_q;
	assign empty  = !out_v_q;

endmodule

// ----- src/laplacian_edge_threshold_unit.sv -----
// Top level: register port, geometry clamp, queue credit and the three parts.
//
// channel   handshake            payload
// sample    push / full          command, grey_pixel
// result    pop / empty          edge_value, last_of_frame
// config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while full is low; products pass s1 to s3 and the queue.
// The line memory takes one write per pixel and one prefetch read per item.
// full rises when the products in flight plus those queued fill the 8-entry queue.
// Reset sets counters, valid flags, config defaults; line memory needs no clearing.
// With pop held low, full rises once nine results are held: one in the output
// register and eight queued or in flight.
module laplacian_edge_threshold_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  lapet_pkg::sample_t                sample,
	output logic                              empty,
	input  logic                              pop,
	output lapet_pkg::result_t                result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lapet_pkg::ADDR_W-1:0]      paddr,
	input  logic [lapet_pkg::DATA_W-1:0]      pwdata,
	output logic [lapet_pkg::DATA_W-1:0]      prdata,
	output logic                              pready
);
	import lapet_pkg::*;

	localparam int EW_W   = $clog2(MAX_WIDTH + 1);
	localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPW_W = (EW_W > DIM_W) ? EW_W : DIM_W;
	localparam int CMPH_W = (EH_W > DIM_W) ? EH_W : DIM_W;
	localparam int QDEPTH = 8;
	localparam int CNT_W  = $clog2(QDEPTH) + 1;
	localparam int OCC_W  = CNT_W + 1;

	logic [DIM_W-1:0]        width_q, height_q;
	logic signed [WGT_W-1:0] center_w_q, neighb_w_q;
	logic signed [THR_W-1:0] threshold_q;

	logic             wr;
	logic             restart;
	logic [IDX_W-1:0] reg_idx;
	logic [CMPW_W-1:0] w_ext;
	logic [CMPH_W-1:0] h_ext;
	logic [EW_W-1:0]  width_eff;
	logic [EH_W-1:0]  height_eff;
	weights_t         weights;

	logic             accept;
	logic             f_push;
	prod_t            f_prod;
	logic [1:0]       inflight;
	prod_t            q_head;
	logic             q_valid, q_pop;
	logic [CNT_W-1:0] q_count;
	logic [OCC_W-1:0] occ;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr      = psel && penable && pwrite && pready;
	assign restart = wr && (reg_idx inside {REG_WIDTH, REG_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			center_w_q  <= CENTER_W_RST;
			neighb_w_q  <= NEIGHB_W_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (wr) begin
			case (reg_idx)
				REG_WIDTH:     width_q     <= pwdata[DIM_W-1:0];
				REG_HEIGHT:    height_q    <= pwdata[DIM_W-1:0];
				REG_CENTER_W:  center_w_q  <= pwdata[WGT_W-1:0];
				REG_NEIGHB_W:  neighb_w_q  <= pwdata[WGT_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:     prdata = DATA_W'(width_q);
			REG_HEIGHT:    prdata = DATA_W'(height_q);
			REG_CENTER_W:  prdata = DATA_W'(center_w_q);
			REG_NEIGHB_W:  prdata = DATA_W'(neighb_w_q);
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	// Geometry outside 2..MAX is clamped
	always_comb begin
		w_ext = CMPW_W'(width_q);
		h_ext = CMPH_W'(height_q);
		if (w_ext < CMPW_W'(2)) begin
			width_eff = EW_W'(2);
		end else if (w_ext > CMPW_W'(MAX_WIDTH)) begin
			width_eff = EW_W'(MAX_WIDTH);
		end else begin
			width_eff = w_ext[EW_W-1:0];
		end
		if (h_ext < CMPH_W'(2)) begin
			height_eff = EH_W'(2);
		end else if (h_ext > CMPH_W'(MAX_HEIGHT)) begin
			height_eff = EH_W'(MAX_HEIGHT);
		end else begin
			height_eff = h_ext[EH_W-1:0];
		end
	end

	assign weights.center    = center_w_q;
	assign weights.neighbour = neighb_w_q;

	// Credit: every product in flight already owns a queue slot
	assign occ    = OCC_W'(q_count) + OCC_W'(inflight);
	assign full   = occ >= OCC_W'(QDEPTH);
	assign accept = push && !full;

	lapet_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (sample),
		.width    (width_eff),
		.height   (height_eff),
		.weights  (weights),
		.restart  (restart),
		.push     (f_push),
		.prod     (f_prod),
		.inflight (inflight)
	);

	lapet_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (f_push),
		.wr_data   (f_prod),
		.rd_en     (q_pop),
		.rd_data   (q_head),
		.not_empty (q_valid),
		.count     (q_count)
	);

	lapet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (q_head),
		.threshold (threshold_q),
		.pop       (pop),
		.q_pop     (q_pop),
		.result    (result),
		.empty     (empty)
	);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCC_W'(QDEPTH))
		else $error("queue credit exceeded");

endmodule
